FILE: hw/rtl/ale_pkg.sv
// ----------------------------------------------------------------------------
// ale_pkg
// Shared types and constants for the array list engine.
// ----------------------------------------------------------------------------
package ale_pkg;

   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int POS_W = 5;
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int VAL_W = 32;

   typedef enum logic [1:0] {
      OP_INSERT_AT     = 2'd0,
      OP_INSERT_SORTED = 2'd1,
      OP_DELETE_AT     = 2'd2,
      OP_LOCATE        = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_FULL    = 2'd1,
      ST_INVALID = 2'd2
   } status_type;

   typedef struct packed {
      op_type                    op;
      logic                      write_en;
      logic signed [VAL_W-1:0]   value;
      logic [CMP_W-1:0]          pos;
      logic [CMP_W-1:0]          count;
   } ctrl_type;

endpackage

FILE: hw/rtl/array_list_engine_unit.sv
// ----------------------------------------------------------------------------
// array_list_engine_unit
// Ordered list of signed 32-bit values with positional and sorted insert,
// positional delete and locate. Every entry sits in its own cell, and a
// match flag and index ripple from cell to cell across the row, so all
// entries compare and shift together on the accepting edge. The result item
// is registered, and a new command is taken in the same cycle that the
// previous result is taken, so the block sustains one item per cycle when
// the result side never stalls.
// ----------------------------------------------------------------------------
module array_list_engine_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // command[1:0], value[33:2], position[38:34], zero fill[39]
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], found[2], found_index[6:3], entry_total[11:7], zero fill[15:12]
   output logic [15:0] rsp_tdata
);
   import ale_pkg::*;

   logic                    accept;
   op_type                  op;
   logic [CMP_W-1:0]        pos;
   logic [CMP_W-1:0]        count_ext;
   status_type              status;
   logic                    apply;
   ctrl_type                ctrl;
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [15:0]             rsp_data_ff;
   logic [15:0]             rsp_data_in;

   logic signed [VAL_W-1:0] entry   [DEPTH];
   logic                    seen    [DEPTH+1];
   logic [IDX_W-1:0]        idx     [DEPTH+1];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign op         = op_type'(req_tdata[1:0]);
   assign pos        = CMP_W'(req_tdata[38:34]);
   assign count_ext  = CMP_W'(count_ff);

   always_comb begin
      status = ST_DONE;
      apply  = 1'b0;
      unique case (op)
         OP_INSERT_AT: begin
            if (count_ff == CNT_W'(DEPTH)) begin
               status = ST_FULL;
            end else if (pos > count_ext) begin
               status = ST_INVALID;
            end else begin
               apply = 1'b1;
            end
         end
         OP_INSERT_SORTED: begin
            if (count_ff == CNT_W'(DEPTH)) begin
               status = ST_FULL;
            end else begin
               apply = 1'b1;
            end
         end
         OP_DELETE_AT: begin
            if (pos >= count_ext) begin
               status = ST_INVALID;
            end else begin
               apply = 1'b1;
            end
         end
         OP_LOCATE: begin
            status = ST_DONE;
         end
         default: begin
            status = ST_DONE;
         end
      endcase
   end

   always_comb begin
      ctrl.op       = op;
      ctrl.write_en = accept && apply;
      ctrl.value    = $signed(req_tdata[33:2]);
      ctrl.pos      = pos;
      ctrl.count    = count_ext;
   end

   assign seen[0] = 1'b0;
   assign idx[0]  = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [VAL_W-1:0] left_entry;
      logic signed [VAL_W-1:0] right_entry;
      if (i == 0) begin : g_first
         assign left_entry = '0;
      end else begin : g_left
         assign left_entry = entry[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_right
         assign right_entry = entry[i+1];
      end
      ale_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .cell_index  (IDX_W'(i)),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .seen_in     (seen[i]),
         .idx_in      (idx[i]),
         .entry       (entry[i]),
         .seen_out    (seen[i+1]),
         .idx_out     (idx[i+1])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (accept && apply) begin
         if (op == OP_DELETE_AT) begin
            count_in = count_ff - CNT_W'(1);
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in      = 1'b1;
         rsp_data_in       = '0;
         rsp_data_in[1:0]  = status;
         if (op == OP_LOCATE) begin
            rsp_data_in[2]   = seen[DEPTH];
            rsp_data_in[6:3] = 4'(idx[DEPTH]);
         end
         rsp_data_in[11:7] = 5'(count_in);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds depth");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && !apply) |=> $stable(count_ff))
      else $error("rejected command changed the entry count");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && apply && (op != OP_DELETE_AT)) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the list by one");
`endif

endmodule

FILE: hw/rtl/ale_cell.sv
// ----------------------------------------------------------------------------
// ale_cell
// One list entry: holds its value, compares it and takes a neighbor's value.
// ----------------------------------------------------------------------------
module ale_cell (
   input  logic                                clock,
   input  ale_pkg::ctrl_type                   ctrl,
   input  logic [ale_pkg::IDX_W-1:0]           cell_index,
   input  logic signed [ale_pkg::VAL_W-1:0]    left_entry,
   input  logic signed [ale_pkg::VAL_W-1:0]    right_entry,
   input  logic                                seen_in,
   input  logic [ale_pkg::IDX_W-1:0]           idx_in,
   output logic signed [ale_pkg::VAL_W-1:0]    entry,
   output logic                                seen_out,
   output logic [ale_pkg::IDX_W-1:0]           idx_out
);
   import ale_pkg::*;

   logic signed [VAL_W-1:0] entry_ff;
   logic signed [VAL_W-1:0] entry_in;
   logic [CMP_W-1:0]        own_pos;
   logic                    live;
   logic                    cond;

   assign own_pos  = CMP_W'(cell_index);
   assign live     = own_pos < ctrl.count;
   assign seen_out = seen_in | cond;
   assign idx_out  = seen_in ? idx_in : (cond ? cell_index : '0);
   assign entry    = entry_ff;

   always_comb begin
      cond     = 1'b0;
      entry_in = entry_ff;
      unique case (ctrl.op)
         OP_INSERT_AT, OP_INSERT_SORTED: begin
            if (ctrl.op == OP_INSERT_AT) begin
               cond = own_pos == ctrl.pos;
            end else begin
               cond = !(live && (entry_ff < ctrl.value));
            end
            if (ctrl.write_en) begin
               if (seen_in) begin
                  entry_in = left_entry;
               end else if (cond) begin
                  entry_in = ctrl.value;
               end
            end
         end
         OP_DELETE_AT: begin
            cond = own_pos == ctrl.pos;
            if (ctrl.write_en && (seen_in || cond)) begin
               entry_in = right_entry;
            end
         end
         OP_LOCATE: begin
            cond = live && (entry_ff == ctrl.value);
         end
         default: begin
            cond = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
